// ===== rtl/phrt_pkg.sv =====
// Shared types and constants for the polygon region hit-test unit.
// No dependencies; used by phrt_edge.sv, polygon_region_hit_test_unit.sv and bench/tb.sv.
package phrt_pkg;

    // Table geometry and coordinate width
    localparam int MAX_REGIONS = 8;
    localparam int MAX_VERTS   = 8;
    localparam int COORD_BITS  = 12;

    localparam int REG_W       = $clog2(MAX_REGIONS);
    localparam int VERT_W      = $clog2(MAX_VERTS);
    localparam int STORE_DEPTH = MAX_REGIONS * MAX_VERTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = 2 * COORD_BITS;

    // Difference of two coordinates and product of two differences
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    // Configuration port
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGIONS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTS_IN_USE   = 1'b1;
    localparam logic [CFG_W-1:0]     REGIONS_RESET      = 4'd0;
    localparam logic [CFG_W-1:0]     VERTS_RESET        = 4'd4;

    // Input item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [2:0]            region;
        logic [2:0]            vertex_index;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } phrt_in_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] region_hit;
    } phrt_out_t;

    // One edge handed to the crossing unit: vertex i is the current one,
    // vertex j the one before it in the walk
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [REG_W-1:0]      region;
        logic [COORD_BITS-1:0] xi;
        logic [COORD_BITS-1:0] yi;
        logic [COORD_BITS-1:0] xj;
        logic [COORD_BITS-1:0] yj;
    } phrt_edge_in_t;

    // Crossing verdict for one edge
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [REG_W-1:0] region;
        logic             toggle;
    } phrt_edge_res_t;

endpackage

// ===== rtl/phrt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module phrt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/phrt_edge.sv =====
// Three-stage crossing unit: straddle test, exact cross-multiplication, compare.
// Depends on phrt_pkg.
module phrt_edge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [phrt_pkg::COORD_BITS-1:0]   px,
    input  logic [phrt_pkg::COORD_BITS-1:0]   py,
    input  phrt_pkg::phrt_edge_in_t           edge_in,
    output phrt_pkg::phrt_edge_res_t          edge_out,
    output logic                              busy
);

    // Stage 1 registers: differences and straddle flag
    logic                               s1_valid_reg;
    logic                               s1_last_reg;
    logic [phrt_pkg::REG_W-1:0]         s1_region_reg;
    logic                               s1_straddle_reg;
    logic                               s1_dy_pos_reg;
    logic signed [phrt_pkg::DIFF_W-1:0] s1_dxp_reg;
    logic signed [phrt_pkg::DIFF_W-1:0] s1_dy_reg;
    logic signed [phrt_pkg::DIFF_W-1:0] s1_dxe_reg;
    logic signed [phrt_pkg::DIFF_W-1:0] s1_dyp_reg;

    // Stage 2 registers: products
    logic                               s2_valid_reg;
    logic                               s2_last_reg;
    logic [phrt_pkg::REG_W-1:0]         s2_region_reg;
    logic                               s2_straddle_reg;
    logic                               s2_dy_pos_reg;
    logic signed [phrt_pkg::PROD_W-1:0] s2_lhs_reg;
    logic signed [phrt_pkg::PROD_W-1:0] s2_rhs_reg;

    // Stage 3 register: verdict
    phrt_pkg::phrt_edge_res_t           s3_reg;
    phrt_pkg::phrt_edge_res_t           s3_next;

    logic signed [phrt_pkg::DIFF_W-1:0] xi_s;
    logic signed [phrt_pkg::DIFF_W-1:0] yi_s;
    logic signed [phrt_pkg::DIFF_W-1:0] xj_s;
    logic signed [phrt_pkg::DIFF_W-1:0] yj_s;
    logic signed [phrt_pkg::DIFF_W-1:0] px_s;
    logic signed [phrt_pkg::DIFF_W-1:0] py_s;
    logic                               left;

    // Zero-extend coordinates to signed difference width
    assign xi_s = $signed({1'b0, edge_in.xi});
    assign yi_s = $signed({1'b0, edge_in.yi});
    assign xj_s = $signed({1'b0, edge_in.xj});
    assign yj_s = $signed({1'b0, edge_in.yj});
    assign px_s = $signed({1'b0, px});
    assign py_s = $signed({1'b0, py});

    // Stage 1: differences, strict-above test on both ends
    always_ff @(posedge clk)
    begin
        s1_last_reg     <= edge_in.last;
        s1_region_reg   <= edge_in.region;
        s1_straddle_reg <= (edge_in.yi > py) != (edge_in.yj > py);
        s1_dy_pos_reg   <= edge_in.yj > edge_in.yi;
        s1_dxp_reg      <= px_s - xi_s;
        s1_dy_reg       <= yj_s - yi_s;
        s1_dxe_reg      <= xj_s - xi_s;
        s1_dyp_reg      <= py_s - yi_s;
    end

    // Stage 2: both products of the cross-multiplication
    always_ff @(posedge clk)
    begin
        s2_last_reg     <= s1_last_reg;
        s2_region_reg   <= s1_region_reg;
        s2_straddle_reg <= s1_straddle_reg;
        s2_dy_pos_reg   <= s1_dy_pos_reg;
        s2_lhs_reg      <= s1_dxp_reg * s1_dy_reg;
        s2_rhs_reg      <= s1_dxe_reg * s1_dyp_reg;
    end

    // Stage 3: compare direction follows the sign of dy
    assign left = s2_dy_pos_reg ? (s2_lhs_reg < s2_rhs_reg) : (s2_lhs_reg > s2_rhs_reg);

    always_comb
    begin
        s3_next.valid  = s2_valid_reg;
        s3_next.last   = s2_last_reg;
        s3_next.region = s2_region_reg;
        s3_next.toggle = s2_straddle_reg & left;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= edge_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_reg       <= s3_next;
        end
    end

    assign edge_out = s3_reg;
    assign busy     = s1_valid_reg | s2_valid_reg | s3_reg.valid;

endmodule

// ===== rtl/polygon_region_hit_test_unit.sv =====
// Polygon region hit-test unit: vertex store, edge walk sequencer, parity accumulation.
// Depends on phrt_pkg, phrt_ram and phrt_edge.
// Vertex write: accepted in idle, no result. Query: a walk over all regions, verdict to the
// output register (R regions, V vertices per region, one vertex read per cycle from the
// single read port of the vertex store); no walk when R or V is zero. One item at a time.
// Reset clears control state; regions_in_use resets to 0, verts_in_use to 4; the vertex
// store is not cleared.
module polygon_region_hit_test_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  phrt_pkg::phrt_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output phrt_pkg::phrt_out_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [phrt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [phrt_pkg::CFG_W-1:0]           cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t                            state_reg, state_next;
    logic [phrt_pkg::CFG_W-1:0]        regions_reg;
    logic [phrt_pkg::CFG_W-1:0]        verts_reg;
    logic [phrt_pkg::COORD_BITS-1:0]   px_reg, px_next;
    logic [phrt_pkg::COORD_BITS-1:0]   py_reg, py_next;
    logic [phrt_pkg::CFG_W-1:0]        nr_reg, nr_next;
    logic [phrt_pkg::CFG_W-1:0]        nv_reg, nv_next;
    logic [phrt_pkg::CFG_W-1:0]        rcnt_reg, rcnt_next;
    logic [phrt_pkg::CFG_W-1:0]        step_reg, step_next;
    logic                              rd_valid_reg, rd_valid_next;
    logic                              rd_first_reg, rd_first_next;
    logic                              rd_last_reg, rd_last_next;
    logic [phrt_pkg::REG_W-1:0]        rd_region_reg, rd_region_next;
    logic [phrt_pkg::COORD_BITS-1:0]   prev_x_reg, prev_x_next;
    logic [phrt_pkg::COORD_BITS-1:0]   prev_y_reg, prev_y_next;
    logic                              parity_reg, parity_next;
    logic                              found_reg, found_next;
    logic [phrt_pkg::REG_W-1:0]        hit_region_reg, hit_region_next;
    logic                              out_valid_reg, out_valid_next;
    phrt_pkg::phrt_out_t               out_data_reg, out_data_next;

    logic                              in_xfer;
    logic                              ram_we;
    logic [phrt_pkg::ADDR_W-1:0]       ram_waddr;
    logic [phrt_pkg::ENTRY_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [phrt_pkg::ADDR_W-1:0]       ram_raddr;
    logic [phrt_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [phrt_pkg::CFG_W-1:0]        vert_sel;
    logic [phrt_pkg::COORD_BITS-1:0]   rd_x;
    logic [phrt_pkg::COORD_BITS-1:0]   rd_y;
    logic                              par;
    phrt_pkg::phrt_edge_in_t           edge_in;
    phrt_pkg::phrt_edge_res_t          edge_res;
    logic                              edge_busy;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Vertex store; writes come only in idle, so they never meet an in-flight read
    assign ram_we    = in_xfer & (in_data.action == phrt_pkg::ACT_WRITE);
    assign ram_waddr = {in_data.region[phrt_pkg::REG_W-1:0],
                        in_data.vertex_index[phrt_pkg::VERT_W-1:0]};
    assign ram_wdata = {in_data.point_y, in_data.point_x};

    // Walk order per region: vertex V-1 first, then vertices 0 .. V-1
    assign vert_sel  = (step_reg == '0) ? (nv_reg - 1'b1) : (step_reg - 1'b1);
    assign ram_re    = (state_reg == S_WALK);
    assign ram_raddr = {rcnt_reg[phrt_pkg::REG_W-1:0], vert_sel[phrt_pkg::VERT_W-1:0]};

    phrt_ram #(
        .WIDTH (phrt_pkg::ENTRY_W),
        .DEPTH (phrt_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[phrt_pkg::COORD_BITS-1:0];
    assign rd_y = ram_rdata[phrt_pkg::ENTRY_W-1:phrt_pkg::COORD_BITS];

    // Pair the vertex just read with the one read before it
    always_comb
    begin
        edge_in.valid  = rd_valid_reg & ~rd_first_reg;
        edge_in.last   = rd_last_reg;
        edge_in.region = rd_region_reg;
        edge_in.xi     = rd_x;
        edge_in.yi     = rd_y;
        edge_in.xj     = prev_x_reg;
        edge_in.yj     = prev_y_reg;
    end

    phrt_edge u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .px       (px_reg),
        .py       (py_reg),
        .edge_in  (edge_in),
        .edge_out (edge_res),
        .busy     (edge_busy)
    );

    assign par = parity_reg ^ edge_res.toggle;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        nr_next         = nr_reg;
        nv_next         = nv_reg;
        rcnt_next       = rcnt_reg;
        step_next       = step_reg;
        rd_valid_next   = 1'b0;
        rd_first_next   = rd_first_reg;
        rd_last_next    = rd_last_reg;
        rd_region_next  = rd_region_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        parity_next     = parity_reg;
        found_next      = found_reg;
        hit_region_next = hit_region_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_data_next   = out_data_reg;

        // Hold the last vertex read as the start of the next edge
        if (rd_valid_reg)
        begin
            prev_x_next = rd_x;
            prev_y_next = rd_y;
        end

        // Accumulate crossings; close out a region on its last edge
        if (edge_res.valid)
        begin
            if (edge_res.last)
            begin
                parity_next = 1'b0;
                if (par && !found_reg)
                begin
                    found_next      = 1'b1;
                    hit_region_next = edge_res.region;
                end
            end
            else
            begin
                parity_next = par;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_data.action == phrt_pkg::ACT_QUERY)
                begin
                    px_next         = in_data.point_x;
                    py_next         = in_data.point_y;
                    nr_next         = (regions_reg > phrt_pkg::CFG_W'(phrt_pkg::MAX_REGIONS))
                                      ? phrt_pkg::CFG_W'(phrt_pkg::MAX_REGIONS) : regions_reg;
                    nv_next         = (verts_reg > phrt_pkg::CFG_W'(phrt_pkg::MAX_VERTS))
                                      ? phrt_pkg::CFG_W'(phrt_pkg::MAX_VERTS) : verts_reg;
                    rcnt_next       = '0;
                    step_next       = '0;
                    parity_next     = 1'b0;
                    found_next      = 1'b0;
                    hit_region_next = '0;
                    if (nr_next == '0 || nv_next == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // Issue one read, tag it, advance vertex and region counters
                rd_valid_next  = 1'b1;
                rd_first_next  = (step_reg == '0);
                rd_last_next   = (step_reg == nv_reg);
                rd_region_next = rcnt_reg[phrt_pkg::REG_W-1:0];
                if (step_reg == nv_reg)
                begin
                    step_next = '0;
                    if (rcnt_reg == nr_reg - 1'b1)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        rcnt_next = rcnt_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !edge_busy)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.hit        = found_reg;
                    out_data_next.region_hit = 3'(hit_region_reg);
                    state_next               = S_IDLE;
                end
            end
        endcase
    end

    // State, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            regions_reg   <= phrt_pkg::REGIONS_RESET;
            verts_reg     <= phrt_pkg::VERTS_RESET;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    phrt_pkg::CFG_REGIONS_IN_USE: regions_reg <= cfg_data;
                    phrt_pkg::CFG_VERTS_IN_USE:   verts_reg   <= cfg_data;
                endcase
            end
        end
    end

    // Working registers of the walk
    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        nr_reg         <= nr_next;
        nv_reg         <= nv_next;
        rcnt_reg       <= rcnt_next;
        step_reg       <= step_next;
        rd_first_reg   <= rd_first_next;
        rd_last_reg    <= rd_last_next;
        rd_region_reg  <= rd_region_next;
        prev_x_reg     <= prev_x_next;
        prev_y_reg     <= prev_y_next;
        parity_reg     <= parity_next;
        found_reg      <= found_next;
        hit_region_reg <= hit_region_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for polygon_region_hit_test_unit: vertex loads and touch queries over
// valid/ready, each query answer checked against an even-odd crossing predictor.
// Depends on rtl/phrt_pkg.sv and rtl/polygon_region_hit_test_unit.sv.
module tb;

    localparam int CLK_HALF      = 6;
    localparam int COORD_MAX     = (1 << phrt_pkg::COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 165;
    localparam int NUM_PHASES    = 8;
    localparam int HOLD_PHASE    = 6;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    phrt_pkg::phrt_in_t             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    phrt_pkg::phrt_out_t            out_data;
    logic                           cfg_we    = 1'b0;
    logic [phrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [phrt_pkg::CFG_W-1:0]     cfg_data  = '0;

    // Items waiting to be driven and answers waiting to come back
    phrt_pkg::phrt_in_t  pending_items[$];
    phrt_pkg::phrt_out_t expected_hits[$];
    phrt_pkg::phrt_out_t oldest_hit;

    // Shadow of the vertex table, updated at each write transfer, and of the registers
    logic [phrt_pkg::COORD_BITS-1:0] vtx_x [phrt_pkg::STORE_DEPTH];
    logic [phrt_pkg::COORD_BITS-1:0] vtx_y [phrt_pkg::STORE_DEPTH];
    logic [phrt_pkg::CFG_W-1:0]      cur_regions = phrt_pkg::REGIONS_RESET;
    logic [phrt_pkg::CFG_W-1:0]      cur_verts   = phrt_pkg::VERTS_RESET;

    // Entries the generator has already queued a write for
    bit loaded [phrt_pkg::STORE_DEPTH];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off       = 1'b0;
    bit pressure_go    = 1'b0;
    int fail_count     = 0;
    int items_queued   = 0;

    polygon_region_hit_test_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int saturate(input logic [phrt_pkg::CFG_W-1:0] v, input int top);
        return (int'(v) > top) ? top : int'(v);
    endfunction

    // Table entry of one vertex
    function automatic logic [phrt_pkg::ADDR_W-1:0] store_addr(input int r, input int k);
        return phrt_pkg::ADDR_W'(r * phrt_pkg::MAX_VERTS + k);
    endfunction

    // Even-odd crossing count over one region, exact integer compare per edge
    function automatic bit polygon_encloses(input int r, input int nv,
                                            input longint px, input longint py);
        bit     enclosed;
        int     prev;
        longint xi, yi, xj, yj, dy, lhs, rhs;
        bit     left;
        enclosed = 1'b0;
        if (nv == 0)
            return 1'b0;
        prev = nv - 1;
        for (int k = 0; k < nv; k++)
        begin
            xi = longint'(vtx_x[store_addr(r, k)]);
            yi = longint'(vtx_y[store_addr(r, k)]);
            xj = longint'(vtx_x[store_addr(r, prev)]);
            yj = longint'(vtx_y[store_addr(r, prev)]);
            if ((yi > py) != (yj > py))
            begin
                dy   = yj - yi;
                lhs  = (px - xi) * dy;
                rhs  = (xj - xi) * (py - yi);
                left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left)
                    enclosed = !enclosed;
            end
            prev = k;
        end
        return enclosed;
    endfunction

    // First region in use that contains the point
    function automatic phrt_pkg::phrt_out_t first_region_hit(
        input logic [phrt_pkg::COORD_BITS-1:0] px,
        input logic [phrt_pkg::COORD_BITS-1:0] py);
        phrt_pkg::phrt_out_t res;
        int                  nr, nv;
        res = '0;
        nr  = saturate(cur_regions, phrt_pkg::MAX_REGIONS);
        nv  = saturate(cur_verts, phrt_pkg::MAX_VERTS);
        for (int r = 0; r < nr; r++)
        begin
            if (!res.hit && polygon_encloses(r, nv, longint'(px), longint'(py)))
            begin
                res.hit        = 1'b1;
                res.region_hit = 3'(r);
            end
        end
        return res;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // Random offset around a center, optionally snapped to a coarse grid
    function automatic int jitter(input int c, input int rad, input int grid);
        int v;
        v = c + int'($urandom_range(2 * rad)) - rad;
        v = (v / grid) * grid;
        return clamp_coord(v);
    endfunction

    // Mostly a corner value, sometimes anything
    function automatic int edge_coord();
        int pick;
        pick = $urandom_range(2);
        return (pick == 0) ? 0 : ((pick == 1) ? COORD_MAX : int'($urandom_range(COORD_MAX)));
    endfunction

    task automatic push_write(input int r, input int k, input int x, input int y);
        phrt_pkg::phrt_in_t item;
        item.action       = phrt_pkg::ACT_WRITE;
        item.region       = 3'(r);
        item.vertex_index = 3'(k);
        item.point_x      = phrt_pkg::COORD_BITS'(x);
        item.point_y      = phrt_pkg::COORD_BITS'(y);
        loaded[store_addr(r, k)] = 1'b1;
        pending_items.push_back(item);
        items_queued++;
    endtask

    // Load any vertex the walk would read before queuing the query
    task automatic push_query(input int x, input int y);
        phrt_pkg::phrt_in_t item;
        int                 nr, nv;
        nr = saturate(cur_regions, phrt_pkg::MAX_REGIONS);
        nv = saturate(cur_verts, phrt_pkg::MAX_VERTS);
        for (int r = 0; r < nr; r++)
            for (int k = 0; k < nv; k++)
                if (!loaded[store_addr(r, k)])
                    push_write(r, k, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
        item.action       = phrt_pkg::ACT_QUERY;
        item.region       = 3'($urandom);
        item.vertex_index = 3'($urandom);
        item.point_x      = phrt_pkg::COORD_BITS'(x);
        item.point_y      = phrt_pkg::COORD_BITS'(y);
        pending_items.push_back(item);
        items_queued++;
    endtask

    // Load a whole polygon for one region, then probe around it
    task automatic push_shape_and_probe();
        int nr, nv, r, cx, cy, rad, grid, probes;
        nr = saturate(cur_regions, phrt_pkg::MAX_REGIONS);
        nv = saturate(cur_verts, phrt_pkg::MAX_VERTS);
        r  = (nr > 0) ? int'($urandom_range(nr - 1))
                      : int'($urandom_range(phrt_pkg::MAX_REGIONS - 1));
        if (nv == 0)
            nv = $urandom_range(phrt_pkg::MAX_VERTS, 3);
        rad  = ($urandom_range(3) == 0) ? int'($urandom_range(2047, 512))
                                        : int'($urandom_range(300, 4));
        cx   = $urandom_range(COORD_MAX);
        cy   = $urandom_range(COORD_MAX);
        grid = $urandom_range(1) ? 32 : 1;
        for (int k = 0; k < nv; k++)
            push_write(r, k, jitter(cx, rad, grid), jitter(cy, rad, grid));
        probes = $urandom_range(5, 1);
        for (int q = 0; q < probes; q++)
            push_query(jitter(cx, rad, grid), jitter(cy, rad, grid));
    endtask

    // Wait until every item is through and every answer is back, then let the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_hits.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers and the idle rates while the block is idle
    task automatic apply_phase(input logic [phrt_pkg::CFG_W-1:0] regions,
                               input logic [phrt_pkg::CFG_W-1:0] verts,
                               input int send_pct, input int recv_pct);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_index   <= phrt_pkg::CFG_REGIONS_IN_USE;
        cfg_data    <= regions;
        cur_regions  = regions;
        @(posedge clk);
        cfg_index   <= phrt_pkg::CFG_VERTS_IN_USE;
        cfg_data    <= verts;
        cur_verts    = verts;
        @(posedge clk);
        cfg_we         <= 1'b0;
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        @(negedge clk);
    endtask

    // Driver: present pending items, idle at random, shadow each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.action == phrt_pkg::ACT_WRITE)
                begin
                    vtx_x[store_addr(int'(in_data.region), int'(in_data.vertex_index))] =
                        in_data.point_x;
                    vtx_y[store_addr(int'(in_data.region), int'(in_data.vertex_index))] =
                        in_data.point_y;
                end
                else
                    expected_hits.push_back(first_region_hit(in_data.point_x, in_data.point_y));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected result: hit %0d region_hit %0d",
                           out_data.hit, out_data.region_hit);
                    fail_count++;
                end
                else
                begin
                    oldest_hit = expected_hits.pop_front();
                    if (out_data.hit !== oldest_hit.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", oldest_hit.hit, out_data.hit);
                        fail_count++;
                    end
                    if (out_data.region_hit !== oldest_hit.region_hit)
                    begin
                        $error("region_hit: expected %0d, actual %0d",
                               oldest_hit.region_hit, out_data.region_hit);
                        fail_count++;
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold off the receiver for a long stretch so the block backs up its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Give up on a hung run
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed checks, then random phases over several settings
    initial
    begin
        int regions_tab [NUM_PHASES] = '{8, 15, 1, 0, 3, 2, 8, 5};
        int verts_tab   [NUM_PHASES] = '{8, 15, 3, 4, 1, 2, 6, 0};
        int send_tab    [NUM_PHASES] = '{0, 60, 0, 28, 0, 60, 0, 28};
        int recv_tab    [NUM_PHASES] = '{0, 0, 60, 28, 0, 0, 60, 28};
        int start;
        int pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a small square inside a full-screen square
        apply_phase(4'd2, 4'd4, 0, 0);
        push_write(0, 0, 100, 100);
        push_write(0, 1, 300, 100);
        push_write(0, 2, 300, 300);
        push_write(0, 3, 100, 300);
        push_write(1, 0, 0, 0);
        push_write(1, 1, COORD_MAX, 0);
        push_write(1, 2, COORD_MAX, COORD_MAX);
        push_write(1, 3, 0, COORD_MAX);
        push_write(7, 7, COORD_MAX, COORD_MAX);
        push_write(7, 0, 0, 0);
        push_query(200, 200);
        push_query(100, 200);
        push_query(300, 200);
        push_query(200, 100);
        push_query(200, 300);
        push_query(100, 100);
        push_query(2000, 2000);
        push_query(0, 0);
        push_query(COORD_MAX, COORD_MAX);
        push_query(COORD_MAX, 0);
        push_query(0, COORD_MAX);
        push_query(COORD_MAX, 2048);
        wait_idle();

        // Random phases: mostly whole polygons with probes, some noise
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_phase(phrt_pkg::CFG_W'(regions_tab[p]), phrt_pkg::CFG_W'(verts_tab[p]),
                        send_tab[p], recv_tab[p]);
            if (p == HOLD_PHASE)
                pressure_go = 1'b1;
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    push_shape_and_probe();
                else if (pick < 82)
                    push_write($urandom_range(phrt_pkg::MAX_REGIONS - 1),
                               $urandom_range(phrt_pkg::MAX_VERTS - 1),
                               $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
                else if (pick < 91)
                    push_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
                else
                    push_query(edge_coord(), edge_coord());
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/phrt_pkg.sv
rtl/phrt_ram.sv
rtl/phrt_edge.sv
rtl/polygon_region_hit_test_unit.sv
bench/tb.sv
